// ===== rtl/core/tiidw_pkg.sv =====
// tiidw_pkg: shared types, widths and helpers for the triangular table idw interpolator
// no dependencies; imported by the front, back, top level and checker
package tiidw_pkg;

  // field widths (fixed by the item formats, sized for the largest grid and table)
  localparam int REFL_W = 17;
  localparam int IDX_W  = 11;
  localparam int VAL_W  = 28;
  localparam int FRAC_W = 16;
  localparam int GRID_W = 6;
  localparam int LOC_W  = 22;
  localparam int DIST_W = 17;
  localparam int D2_W   = 34;
  localparam int WGT_W  = 35;
  localparam int WLO_W  = 18;
  localparam int ACC_W  = 64;
  localparam int WSUM_W = 37;
  localparam int STEP_W = 7;
  localparam int NB_N   = 4;

  localparam logic [REFL_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [WGT_W-1:0]  WGT_NUM    = 35'h4_0000_0000;
  localparam logic [STEP_W-1:0] STEP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_HIT    = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_LOAD,
    K_QUERY,
    K_REJECT,
    K_HIT
  } kind_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_HIT,
    B_NB,
    B_SQ,
    B_D2,
    B_DIV,
    B_M1,
    B_M2,
    B_FIN,
    B_FDIV,
    B_OUT
  } bstate_e;

  typedef logic [GRID_W-1:0] grid_t;

  // one classified request between front and back
  typedef struct packed {
    kind_e                        kind;
    logic [IDX_W-1:0]             addr;
    logic [VAL_W-1:0]             absv;
    logic [VAL_W-1:0]             scav;
    logic [LOC_W-1:0]             ac_loc;
    logic [LOC_W-1:0]             dc_loc;
    grid_t                        a_dn;
    grid_t                        a_up;
    grid_t                        d_lf;
    grid_t                        d_rt;
    logic [NB_N-1:0]              nb_ok;
    logic [NB_N-1:0][IDX_W-1:0]   nb_idx;
  } entry_t;

  // flat index of grid point (a, d) in the lower-triangular layout
  function automatic logic [IDX_W-1:0] flat_idx(grid_t a, grid_t d);
    logic [2*GRID_W-1:0] prod;
    prod = (2*GRID_W)'(d) * (2*GRID_W)'(d - 1'b1);
    return IDX_W'(a) + IDX_W'(prod[2*GRID_W-1:1]);
  endfunction

endpackage

// ===== rtl/core/tiidw_ram.sv =====
// tiidw_ram: generic single write port, single read port ram with registered read
// no dependencies
module tiidw_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 2048
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/tiidw_div.sv =====
// tiidw_div: restoring divider, one quotient bit per cycle
// no dependencies; quotient must fit in QW bits
module tiidw_div #(
  parameter int NW = 35,
  parameter int DW = 34,
  parameter int QW = 35
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);
  localparam int PW = DW + NW;
  localparam int CW = $clog2(QW + 1);

  logic [PW-1:0] pair_q, pair_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          ge;
  logic [DW-1:0] rem_new;

  // one long-division step
  always_comb begin
    trial   = pair_q[PW-1:NW-1];
    diff    = trial - {1'b0, den_q};
    ge      = (trial >= {1'b0, den_q});
    rem_new = ge ? diff[DW-1:0] : trial[DW-1:0];
    if (start_i) begin
      pair_d = {{DW{1'b0}}, num_i} << (NW - QW);
    end else begin
      pair_d = {rem_new, pair_q[NW-2:0], ge};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    if (start_i || busy_q) begin
      pair_q <= pair_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = pair_q[QW-1:0];
endmodule

// ===== rtl/core/tiidw_fifo.sv =====
// tiidw_fifo: small request queue between front and back
// no dependencies
module tiidw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= din_i;
    end
  end

  assign dout_o  = slot_q[rp_q];
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
endmodule

// ===== rtl/core/tiidw_front.sv =====
// tiidw_front: accepts input items, holds grid_steps, locates queries on the grid
// depends on tiidw_pkg
module tiidw_front
  import tiidw_pkg::*;
#(
  parameter int MAX_STEPS   = 64,
  parameter int TABLE_DEPTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [STEP_W-1:0] cfg_wr_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tuser_i,
  input  logic [103:0]      s_tdata_i,
  output logic              s_tready_o,
  input  logic              full_i,
  output logic              push_o,
  output entry_t            entry_o
);
  localparam logic [STEP_W-1:0] MAXS    = STEP_W'(MAX_STEPS);
  localparam logic [IDX_W:0]    DEPTH_L = (IDX_W + 1)'(TABLE_DEPTH);

  logic [STEP_W-1:0] steps_q, steps, s1;
  grid_t             s1_g, ac_i, dc_i, a_up, d_rt;
  logic [REFL_W-1:0] dc, ac;
  logic [LOC_W-1:0]  ac_loc, dc_loc;
  logic              reject, load_ok, on_grid;
  grid_t             na [NB_N];
  grid_t             nd [NB_N];
  logic [NB_N-1:0]             nb_ok;
  logic [NB_N-1:0][IDX_W-1:0]  nb_idx;

  // step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEP_RESET;
    end else if (cfg_wr_en_i) begin
      steps_q <= cfg_wr_data_i;
    end
  end

  // grid location and neighbour classification
  always_comb begin
    steps = (steps_q < STEP_W'(2)) ? STEP_W'(2) : ((steps_q > MAXS) ? MAXS : steps_q);
    s1    = steps - 1'b1;
    s1_g  = s1[GRID_W-1:0];
    dc    = s_tdata_i[83:67];
    ac    = s_tdata_i[100:84];
    reject = (dc > ONE_Q16) || (ac > ONE_Q16) || (dc <= ac);
    ac_loc = LOC_W'(ac) * LOC_W'(s1_g);
    dc_loc = LOC_W'(dc) * LOC_W'(s1_g);
    ac_i   = ac_loc[LOC_W-1:FRAC_W];
    dc_i   = dc_loc[LOC_W-1:FRAC_W];
    a_up   = (ac_i == s1_g) ? s1_g : ac_i + 1'b1;
    d_rt   = (dc_i == s1_g) ? s1_g : dc_i + 1'b1;
    na[0] = a_up; nd[0] = dc_i;
    na[1] = ac_i; nd[1] = dc_i;
    na[2] = a_up; nd[2] = d_rt;
    na[3] = ac_i; nd[3] = d_rt;
    for (int k = 0; k < NB_N; k++) begin
      nb_idx[k] = flat_idx(na[k], nd[k]);
      nb_ok[k]  = (nd[k] != '0) && (na[k] < nd[k]) && ({1'b0, nb_idx[k]} < DEPTH_L);
    end
    on_grid = (ac_loc[FRAC_W-1:0] == '0) && (dc_loc[FRAC_W-1:0] == '0) && nb_ok[1];
    load_ok = ({1'b0, s_tdata_i[10:0]} < DEPTH_L);
  end

  // request packing
  always_comb begin
    entry_o.addr   = s_tdata_i[10:0];
    entry_o.absv   = s_tdata_i[38:11];
    entry_o.scav   = s_tdata_i[66:39];
    entry_o.ac_loc = ac_loc;
    entry_o.dc_loc = dc_loc;
    entry_o.a_dn   = ac_i;
    entry_o.a_up   = a_up;
    entry_o.d_lf   = dc_i;
    entry_o.d_rt   = d_rt;
    entry_o.nb_ok  = nb_ok;
    entry_o.nb_idx = nb_idx;
    if (!s_tuser_i) begin
      entry_o.kind = K_LOAD;
    end else if (reject) begin
      entry_o.kind = K_REJECT;
    end else if (on_grid) begin
      entry_o.kind = K_HIT;
      entry_o.addr = nb_idx[1];
    end else begin
      entry_o.kind = K_QUERY;
    end
  end

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i && (s_tuser_i || load_ok);
endmodule

// ===== rtl/core/tiidw_back.sv =====
// tiidw_back: executes loads and queries against the table, weights and blends neighbours
// depends on tiidw_pkg, tiidw_ram, tiidw_div
module tiidw_back
  import tiidw_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  entry_t               entry_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [VAL_W-1:0]     abs_o,
  output logic [VAL_W-1:0]     sca_o,
  output status_e              status_o
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  bstate_e            state_q, state_d;
  entry_t             ent_q;
  logic [1:0]         k_q;
  logic [DIST_W-1:0]  dx_q, dy_q, dx, dy;
  logic [D2_W-1:0]    d2_q;
  logic [WGT_W-1:0]   w_q;
  logic [ACC_W-1:0]   acc_a_q, acc_s_q;
  logic [WSUM_W-1:0]  wsum_q;
  logic [VAL_W-1:0]   res_a_q, res_s_q, out_a_q, out_s_q;
  status_e            res_st_q, out_st_q;
  logic               out_valid_q, can_out;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [2*VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0]   rd_a, rd_s;

  logic               wdiv_start, wdiv_done, fdiv_start, fa_done, fs_done;
  logic [WGT_W-1:0]   wdiv_q;
  logic [VAL_W-1:0]   fa_q, fs_q;
  logic [ACC_W-1:0]   num_a, num_s;

  grid_t              cur_a, cur_d;
  logic [LOC_W-1:0]   pa, pd;
  logic [WLO_W-1:0]   wpart;
  logic [ACC_W-1:0]   prod_a, prod_s;

  // table memory: {scattering, absorption}
  tiidw_ram #(.WIDTH(2 * VAL_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_i.addr[AW-1:0]),
    .wdata_i ({entry_i.scav, entry_i.absv}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
  assign rd_a = ram_rdata[VAL_W-1:0];
  assign rd_s = ram_rdata[2*VAL_W-1:VAL_W];

  // inverse squared distance weight
  tiidw_div #(.NW(WGT_W), .DW(D2_W), .QW(WGT_W)) u_wdiv (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (wdiv_start),
    .num_i (WGT_NUM), .den_i (d2_q), .done_o (wdiv_done), .quo_o (wdiv_q)
  );

  // rounded weighted means
  assign num_a = acc_a_q + ACC_W'(wsum_q >> 1);
  assign num_s = acc_s_q + ACC_W'(wsum_q >> 1);

  tiidw_div #(.NW(ACC_W), .DW(WSUM_W), .QW(VAL_W)) u_fdiv_a (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (fdiv_start),
    .num_i (num_a), .den_i (wsum_q), .done_o (fa_done), .quo_o (fa_q)
  );

  tiidw_div #(.NW(ACC_W), .DW(WSUM_W), .QW(VAL_W)) u_fdiv_s (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (fdiv_start),
    .num_i (num_s), .den_i (wsum_q), .done_o (fs_done), .quo_o (fs_q)
  );

  // neighbour distance and partial products against the table entry read
  always_comb begin
    cur_a = k_q[0] ? ent_q.a_dn : ent_q.a_up;
    cur_d = k_q[1] ? ent_q.d_rt : ent_q.d_lf;
    pa    = {cur_a, {FRAC_W{1'b0}}};
    pd    = {cur_d, {FRAC_W{1'b0}}};
    dx    = DIST_W'((pa > ent_q.ac_loc) ? pa - ent_q.ac_loc : ent_q.ac_loc - pa);
    dy    = DIST_W'((pd > ent_q.dc_loc) ? pd - ent_q.dc_loc : ent_q.dc_loc - pd);
    wpart = (state_q == B_M1) ? w_q[WLO_W-1:0] : WLO_W'(w_q[WGT_W-1:WLO_W]);
    prod_a = ACC_W'(wpart) * ACC_W'(rd_a);
    prod_s = ACC_W'(wpart) * ACC_W'(rd_s);
    if (state_q == B_M2) begin
      prod_a = prod_a << WLO_W;
      prod_s = prod_s << WLO_W;
    end
  end

  assign can_out = !out_valid_q || m_tready_i;

  // sequencer: next state and strobes
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = entry_i.addr[AW-1:0];
    wdiv_start = 1'b0;
    fdiv_start = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (entry_i.kind)
            K_LOAD:   ram_we = 1'b1;
            K_REJECT: state_d = B_OUT;
            K_HIT: begin
              ram_re  = 1'b1;
              state_d = B_HIT;
            end
            default:  state_d = B_NB;
          endcase
        end
      end
      B_HIT: state_d = B_OUT;
      B_NB: begin
        ram_raddr = ent_q.nb_idx[k_q][AW-1:0];
        if (ent_q.nb_ok[k_q]) begin
          ram_re  = 1'b1;
          state_d = B_SQ;
        end else if (k_q == 2'd3) begin
          state_d = B_FIN;
        end
      end
      B_SQ: state_d = B_D2;
      B_D2: begin
        if (d2_q == '0) begin
          state_d = B_OUT;
        end else begin
          wdiv_start = 1'b1;
          state_d    = B_DIV;
        end
      end
      B_DIV: if (wdiv_done) state_d = B_M1;
      B_M1:  state_d = B_M2;
      B_M2:  state_d = (k_q == 2'd3) ? B_FIN : B_NB;
      B_FIN: begin
        if (wsum_q == '0) begin
          state_d = B_OUT;
        end else begin
          fdiv_start = 1'b1;
          state_d    = B_FDIV;
        end
      end
      B_FDIV: if (fa_done && fs_done) state_d = B_OUT;
      B_OUT:  if (can_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && can_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_IDLE) begin
        k_q <= '0;
      end else if ((state_q == B_NB && !ent_q.nb_ok[k_q]) || state_q == B_M2) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q   <= entry_i;
      acc_a_q <= '0;
      acc_s_q <= '0;
      wsum_q  <= '0;
      res_a_q <= '0;
      res_s_q <= '0;
      res_st_q <= ST_REJECT;
    end
    if (state_q == B_NB) begin
      dx_q <= dx;
      dy_q <= dy;
    end
    if (state_q == B_SQ) begin
      d2_q <= D2_W'(dx_q) * D2_W'(dx_q) + D2_W'(dy_q) * D2_W'(dy_q);
    end
    if (state_q == B_HIT || (state_q == B_D2 && d2_q == '0)) begin
      res_a_q  <= rd_a;
      res_s_q  <= rd_s;
      res_st_q <= ST_HIT;
    end
    if (state_q == B_DIV && wdiv_done) begin
      w_q    <= wdiv_q;
      wsum_q <= wsum_q + WSUM_W'(wdiv_q);
    end
    if (state_q == B_M1 || state_q == B_M2) begin
      acc_a_q <= acc_a_q + prod_a;
      acc_s_q <= acc_s_q + prod_s;
    end
    if (state_q == B_FDIV && fa_done && fs_done) begin
      res_a_q  <= fa_q;
      res_s_q  <= fs_q;
      res_st_q <= ST_INTERP;
    end
    if (state_q == B_OUT && can_out) begin
      out_a_q  <= res_a_q;
      out_s_q  <= res_s_q;
      out_st_q <= res_st_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign abs_o      = out_a_q;
  assign sca_o      = out_s_q;
  assign status_o   = out_st_q;
endmodule

// ===== rtl/core/triangular_table_idw_interpolator_top.sv =====
// triangular_table_idw_interpolator_top: top level of the table interpolator
// depends on tiidw_pkg, tiidw_front, tiidw_fifo, tiidw_back
//
// Usage:
//   Input stream s_axis_*: tuser is the command (0 load entry, 1 query). Loads
//   write one (absorption, scattering) pair into the triangular table; a load
//   beyond the table depth is dropped. Queries bring DC and AC reflectance in
//   Q1.16 and return one item on m_axis_*: tdata holds absorption and
//   scattering in Q4.24, tuser the status (interpolated, exact hit, rejected).
//   Loads return nothing. cfg_wr_en_i writes grid_steps (used clamped to
//   2..MAX_STEPS) and may only be written while the block is idle.
// Flow:
//   The front classifies one item per cycle into a two-entry queue while the
//   queue is not full. The back drains it one entry at a time: a load writes
//   the table as it is popped, a reject goes straight to the output, an exact
//   hit reads the table first, and an interpolated query weighs each valid
//   neighbour with the bit-serial weight divider, skips invalid ones, and ends
//   in the final pair of dividers. Results pass through the output register.
// Reset: clears queue, sequencer, output valid; grid_steps returns to 64.
//   Table contents are undefined until written.
// Stall: the result waits in the output register; the back holds its next
//   result and the queue fills, after which s_axis_tready drops.
module triangular_table_idw_interpolator_top
  import tiidw_pkg::*;
#(
  parameter int MAX_STEPS   = 64,
  parameter int TABLE_DEPTH = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [6:0]    cfg_wr_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // entry_index, entry_absorption, entry_scattering, refl_dc, refl_ac, 3 pad bits
  input  logic [103:0]  s_axis_tdata_i,
  // command
  input  logic          s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // absorption_out, scattering_out
  output logic [55:0]   m_axis_tdata_o,
  // status
  output logic [1:0]    m_axis_tuser_o
);
  localparam int EW = $bits(entry_t);

  logic             push, full, pop, empty;
  entry_t           front_entry, back_entry;
  logic [EW-1:0]    fifo_dout;
  logic [VAL_W-1:0] abs_out, sca_out;
  status_e          status;

  // front: accept and classify
  tiidw_front #(.MAX_STEPS(MAX_STEPS), .TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tuser_i     (s_axis_tuser_i),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tready_o    (s_axis_tready_o),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  // request queue
  tiidw_fifo #(.WIDTH(EW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (fifo_dout),
    .empty_o (empty)
  );
  assign back_entry = entry_t'(fifo_dout);

  // back: table access and interpolation
  tiidw_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (back_entry),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .abs_o      (abs_out),
    .sca_o      (sca_out),
    .status_o   (status)
  );

  assign m_axis_tdata_o = {sca_out, abs_out};
  assign m_axis_tuser_o = status;
endmodule

// ===== rtl/core/tiidw_checker.sv =====
// tiidw_checker: port-level assertions for the interpolator, bound to the top level
// depends on tiidw_pkg
module tiidw_checker
  import tiidw_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_wr_en_i,
  input logic [6:0]   cfg_wr_data_i,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [103:0] s_axis_tdata_i,
  input logic         s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [55:0]  m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // status is a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_INTERP || m_axis_tuser_o == ST_HIT
                         || m_axis_tuser_o == ST_REJECT))
    else $error("undefined status");

  // rejected results carry zeros
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_REJECT |-> m_axis_tdata_o == '0)
    else $error("reject with nonzero data");

  // no result as reset is released, before any query is accepted
  a_no_early: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result right after reset");
endmodule

bind triangular_table_idw_interpolator_top tiidw_checker u_tiidw_checker (.*);
